>>> rtl/plr_pkg.sv
// Package for the partition local renumbering block.
// Holds field widths, node map geometry and the structs shared by the modules.
// No dependencies.
package plr_pkg;

  localparam int MAX_PARTS = 8;
  localparam int MAX_NODES = 16384;
  localparam int MAX_ELEMS = 32768;

  localparam int PART_W = 3;
  localparam int ID_W   = 15;
  localparam int ELEM_W = 16;
  localparam int NODE_W = 15;

  localparam int PIDX_W    = $clog2(MAX_PARTS);
  localparam int SLOT_W    = $clog2(MAX_NODES);
  localparam int ADDR_W    = PIDX_W + SLOT_W;
  localparam int MAP_DEPTH = MAX_PARTS * MAX_NODES;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [NODE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [ELEM_W-1:0] elem_global;
    logic [ELEM_W-1:0] elem_local;
    logic [NODE_W-1:0] local_a;
    logic [NODE_W-1:0] local_b;
    logic [NODE_W-1:0] local_c;
    logic              new_a;
    logic              new_b;
    logic              new_c;
    logic              overflow;
  } result_t;

endpackage

>>> rtl/plr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds when no read is enabled. No dependencies.
module plr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/plr_ctrl.sv
// Sequencer for the partition local renumbering block: node map clearing pass,
// per-corner read-modify-write of the node map, and the partition counters.
// Depends on plr_pkg.
module plr_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [plr_pkg::PART_W-1:0]      part,
  input  logic [plr_pkg::ID_W-1:0]        corner_a,
  input  logic [plr_pkg::ID_W-1:0]        corner_b,
  input  logic [plr_pkg::ID_W-1:0]        corner_c,
  output plr_pkg::mem_req_t               mem_req,
  input  logic [plr_pkg::NODE_W-1:0]      mem_rdata,
  output logic                            res_valid,
  input  logic                            res_ready,
  output plr_pkg::result_t                res
);
  import plr_pkg::*;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_A    = 3'd2;
  localparam logic [2:0] ST_B    = 3'd3;
  localparam logic [2:0] ST_C    = 3'd4;
  localparam logic [2:0] ST_D    = 3'd5;
  localparam logic [2:0] ST_OVF  = 3'd6;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [ADDR_W-1:0] clr_cnt;
  logic [PIDX_W-1:0] part_q;
  logic [SLOT_W-1:0] slot_a;
  logic [SLOT_W-1:0] slot_b;
  logic [SLOT_W-1:0] slot_c;
  logic [NODE_W-1:0] loc_a;
  logic [NODE_W-1:0] loc_b;
  logic              nw_a;
  logic              nw_b;
  logic [NODE_W-1:0] cnt;
  logic [ELEM_W-1:0] elems_seen;
  logic [ELEM_W-1:0] elem_cnt [MAX_PARTS];
  logic [NODE_W-1:0] node_cnt [MAX_PARTS];

  logic              accept;
  logic              finish;
  logic [PIDX_W-1:0] part_in;
  logic [ID_W-1:0]   id_a_m1;
  logic [ID_W-1:0]   id_b_m1;
  logic [ID_W-1:0]   id_c_m1;
  logic [ELEM_W-1:0] seen_now;
  logic [SLOT_W-1:0] cur_slot;
  logic              fwd_hit;
  logic [NODE_W-1:0] fwd_val;
  logic [NODE_W-1:0] cur_val;
  logic              is_new;
  logic [NODE_W-1:0] cnt_plus;
  logic [NODE_W-1:0] cur_loc;
  logic [NODE_W-1:0] cnt_final;

  // An item finishes in its last state once the output side can take the word.
  assign finish   = ((state == ST_D) || (state == ST_OVF)) && res_ready;
  assign in_stall = !((state == ST_IDLE) || finish);
  assign accept   = in_valid && !in_stall;

  assign part_in = part[PIDX_W-1:0];
  assign id_a_m1 = corner_a - ID_W'(1);
  assign id_b_m1 = corner_b - ID_W'(1);
  assign id_c_m1 = corner_c - ID_W'(1);

  // The element count advances in the same edge that the next item is taken.
  assign seen_now = (state == ST_D) ? elems_seen + ELEM_W'(1) : elems_seen;

  // Later corners of the same item take the value an earlier corner settled,
  // since the memory may not have it yet.
  always_comb begin
    cur_slot = slot_a;
    fwd_hit  = 1'b0;
    fwd_val  = loc_a;
    unique case (state)
      ST_C: begin
        cur_slot = slot_b;
        fwd_hit  = (slot_b == slot_a);
        fwd_val  = loc_a;
      end
      ST_D: begin
        cur_slot = slot_c;
        if (slot_c == slot_b) begin
          fwd_hit = 1'b1;
          fwd_val = loc_b;
        end else begin
          fwd_hit = (slot_c == slot_a);
          fwd_val = loc_a;
        end
      end
      default: begin
        cur_slot = slot_a;
      end
    endcase
  end

  assign cur_val   = fwd_hit ? fwd_val : mem_rdata;
  assign is_new    = (cur_val == '0);
  assign cnt_plus  = cnt + NODE_W'(1);
  assign cur_loc   = is_new ? cnt_plus : cur_val;
  assign cnt_final = is_new ? cnt_plus : cnt;

  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = {part_q, cur_slot};
    mem_req.wdata = cnt_plus;
    mem_req.re    = 1'b0;
    mem_req.raddr = {part_q, slot_a};
    unique case (state)
      ST_CLR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_cnt;
        mem_req.wdata = '0;
      end
      ST_A: begin
        mem_req.re = 1'b1;
      end
      ST_B: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = {part_q, slot_b};
        mem_req.we    = is_new;
      end
      ST_C: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = {part_q, slot_c};
        mem_req.we    = is_new;
      end
      ST_D: begin
        mem_req.we = is_new && res_ready;
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_valid = (state == ST_D) || (state == ST_OVF);
    if (state == ST_D) begin
      res.elem_global = elems_seen + ELEM_W'(1);
      res.elem_local  = elem_cnt[part_q] + ELEM_W'(1);
      res.local_a     = loc_a;
      res.local_b     = loc_b;
      res.local_c     = cur_loc;
      res.new_a       = nw_a;
      res.new_b       = nw_b;
      res.new_c       = is_new;
      res.overflow    = 1'b0;
    end else begin
      res          = '0;
      res.overflow = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR: begin
        if (clr_cnt == ADDR_W'(MAP_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_A: state_next = ST_B;
      ST_B: state_next = ST_C;
      ST_C: state_next = ST_D;
      ST_IDLE, ST_D, ST_OVF: begin
        if (accept) begin
          state_next = (seen_now == ELEM_W'(MAX_ELEMS)) ? ST_OVF : ST_A;
        end else if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      clr_cnt    <= '0;
      elems_seen <= '0;
      for (int i = 0; i < MAX_PARTS; i++) begin
        elem_cnt[i] <= '0;
        node_cnt[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == ST_CLR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if ((state == ST_D) && res_ready) begin
        elems_seen       <= elems_seen + ELEM_W'(1);
        elem_cnt[part_q] <= elem_cnt[part_q] + ELEM_W'(1);
        node_cnt[part_q] <= cnt_final;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      part_q <= part_in;
      slot_a <= id_a_m1[SLOT_W-1:0];
      slot_b <= id_b_m1[SLOT_W-1:0];
      slot_c <= id_c_m1[SLOT_W-1:0];
      // The finishing item may belong to the same partition.
      if ((state == ST_D) && (part_in == part_q)) begin
        cnt <= cnt_final;
      end else begin
        cnt <= node_cnt[part_in];
      end
    end else if ((state == ST_B) || (state == ST_C)) begin
      cnt <= cnt_final;
    end
    if (state == ST_B) begin
      loc_a <= cur_loc;
      nw_a  <= is_new;
    end
    if (state == ST_C) begin
      loc_b <= cur_loc;
      nw_b  <= is_new;
    end
  end

endmodule

>>> rtl/partition_local_renumber_core.sv
// Partition local renumbering of triangle mesh elements, top level.
// An accepted word passes through states ST_A, ST_B, ST_C and ST_D; its result enters the
// output register as ST_D finishes. A new word is taken only as the last one finishes, as
// the three node map reads share the node map RAM's single read port; overflow words use ST_OVF.
// Reset: rst is synchronous; afterwards a clearing pass zeroes all 131072 node map entries,
// one entry a cycle, while no input word is accepted.
module partition_local_renumber_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [plr_pkg::PART_W-1:0]  part,
  input  logic [plr_pkg::ID_W-1:0]    corner_a,
  input  logic [plr_pkg::ID_W-1:0]    corner_b,
  input  logic [plr_pkg::ID_W-1:0]    corner_c,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [plr_pkg::ELEM_W-1:0]  elem_global,
  output logic [plr_pkg::ELEM_W-1:0]  elem_local,
  output logic [plr_pkg::NODE_W-1:0]  local_a,
  output logic [plr_pkg::NODE_W-1:0]  local_b,
  output logic [plr_pkg::NODE_W-1:0]  local_c,
  output logic                        new_a,
  output logic                        new_b,
  output logic                        new_c,
  output logic                        overflow
);
  import plr_pkg::*;

  mem_req_t          mem_req;
  logic [NODE_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  result_t           res;

  assign res_ready = !out_valid || !out_stall;

  plr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .part      (part),
    .corner_a  (corner_a),
    .corner_b  (corner_b),
    .corner_c  (corner_c),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  plr_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAP_DEPTH)
  ) u_node_map (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      elem_global <= res.elem_global;
      elem_local  <= res.elem_local;
      local_a     <= res.local_a;
      local_b     <= res.local_b;
      local_c     <= res.local_c;
      new_a       <= res.new_a;
      new_b       <= res.new_b;
      new_c       <= res.new_c;
      overflow    <= res.overflow;
    end
  end

  // A numbered corner always has a nonzero local index.
  a_local_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !overflow |-> (local_a != '0) && (local_b != '0) && (local_c != '0))
    else $error("zero local node index in a result word");

  // An overflow word carries nothing but the flag.
  a_overflow_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> (elem_global == '0) && !new_a && !new_b && !new_c)
    else $error("overflow word carries data");

  // The cycle after a word is taken only reads the node map.
  a_no_write_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !mem_req.we)
    else $error("node map written while first corner is being read");

endmodule

>>> tb/tb_partition_local_renumber_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for partition_local_renumber_core.
// Holds a scoreboard class that renumbers each accepted word on its own, a task that drives the
// input channel and an always block that drives out_stall; depends on plr_pkg and the core RTL only.
module tb_partition_local_renumber_core;
  import plr_pkg::*;

  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_WORDS = 800;
  localparam int MAX_ID       = (1 << ID_W) - 1;

  class renumber_scoreboard;
    bit [NODE_W-1:0] node_local [MAP_DEPTH];
    int unsigned elem_count [MAX_PARTS];
    int unsigned node_count [MAX_PARTS];
    int unsigned elems_seen;
    int unsigned words_checked;
    int unsigned errors;
    result_t pending_results [$];

    // Numbers one accepted word exactly as the core should and queues the result.
    function void note_word(bit [PART_W-1:0] p_in, bit [ID_W-1:0] ca, bit [ID_W-1:0] cb,
                            bit [ID_W-1:0] cc);
      result_t r;
      bit [ID_W-1:0] ids [3];
      bit [NODE_W-1:0] lidx [3];
      bit fresh [3];
      int unsigned pi;
      int unsigned slot;
      int unsigned addr;
      r = '0;
      if (elems_seen >= MAX_ELEMS) begin
        r.overflow = 1'b1;
        pending_results.insert(pending_results.size(), r);
        return;
      end
      pi = p_in % MAX_PARTS;
      ids[0] = ca;
      ids[1] = cb;
      ids[2] = cc;
      // Corners go in order, so a repeated corner sees the index its twin just took.
      for (int k = 0; k < 3; k++) begin
        slot = (ids[k] % MAX_NODES + MAX_NODES - 1) % MAX_NODES;
        addr = pi * MAX_NODES + slot;
        fresh[k] = (node_local[addr] == '0);
        if (fresh[k]) begin
          node_count[pi]++;
          node_local[addr] = NODE_W'(node_count[pi]);
        end
        lidx[k] = node_local[addr];
      end
      r.elem_global = ELEM_W'(elems_seen + 1);
      r.elem_local  = ELEM_W'(elem_count[pi] + 1);
      r.local_a     = lidx[0];
      r.local_b     = lidx[1];
      r.local_c     = lidx[2];
      r.new_a       = fresh[0];
      r.new_b       = fresh[1];
      r.new_c       = fresh[2];
      elem_count[pi]++;
      elems_seen++;
      pending_results.insert(pending_results.size(), r);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at result %0d: %s", words_checked, msg);
      errors++;
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want)
        report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with no word pending");
      end else begin
        want = pending_results.pop_front();
        compare_field("elem_global", got.elem_global, want.elem_global);
        compare_field("elem_local", got.elem_local, want.elem_local);
        compare_field("local_a", got.local_a, want.local_a);
        compare_field("local_b", got.local_b, want.local_b);
        compare_field("local_c", got.local_c, want.local_c);
        compare_field("new_a", got.new_a, want.new_a);
        compare_field("new_b", got.new_b, want.new_b);
        compare_field("new_c", got.new_c, want.new_c);
        compare_field("overflow", got.overflow, want.overflow);
      end
      words_checked++;
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [PART_W-1:0] part = '0;
  logic [ID_W-1:0]   corner_a = '0;
  logic [ID_W-1:0]   corner_b = '0;
  logic [ID_W-1:0]   corner_c = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ELEM_W-1:0] elem_global;
  logic [ELEM_W-1:0] elem_local;
  logic [NODE_W-1:0] local_a;
  logic [NODE_W-1:0] local_b;
  logic [NODE_W-1:0] local_c;
  logic              new_a;
  logic              new_b;
  logic              new_c;
  logic              overflow;
  result_t           out_word;

  int send_idle = 0;
  int recv_idle = 0;
  renumber_scoreboard sb;

  partition_local_renumber_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .part(part), .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .out_valid(out_valid), .out_stall(out_stall),
    .elem_global(elem_global), .elem_local(elem_local),
    .local_a(local_a), .local_b(local_b), .local_c(local_c),
    .new_a(new_a), .new_b(new_b), .new_c(new_c), .overflow(overflow)
  );

  assign out_word = {elem_global, elem_local, local_a, local_b, local_c,
                     new_a, new_b, new_c, overflow};

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(out_word);
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // Offers one word, holding it until accepted; valid stays high for a word that follows.
  task automatic send_word(input logic [PART_W-1:0] p, input logic [ID_W-1:0] a,
                           input logic [ID_W-1:0] b, input logic [ID_W-1:0] c);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    part     <= p;
    corner_a <= a;
    corner_b <= b;
    corner_c <= c;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sb.note_word(p, a, b, c);
  endtask

  // Mostly small ids so nodes get shared, with some wide and wrapping ones.
  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(9))
      6, 7:    return ID_W'($urandom_range(1, MAX_NODES));
      8:       return ID_W'($urandom_range(0, MAX_ID));
      9: begin
        case ($urandom_range(4))
          0:       return '0;
          1:       return ID_W'(1);
          2:       return ID_W'(MAX_NODES);
          3:       return ID_W'(MAX_NODES + 1);
          default: return ID_W'(MAX_ID);
        endcase
      end
      default: return ID_W'($urandom_range(1, 48));
    endcase
  endfunction

  task automatic send_random_word();
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
    logic [ID_W-1:0] c;
    a = pick_id();
    b = ($urandom_range(99) < 15) ? a : pick_id();
    c = pick_id();
    if ($urandom_range(99) < 10)
      c = $urandom_range(1) ? a : b;
    send_word(PART_W'($urandom_range(MAX_PARTS - 1)), a, b, c);
  endtask

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed words: fresh and known nodes, repeated corners, wrapped ids, every partition.
    send_word(0, 1, 2, 3);
    send_word(0, 3, 2, 1);
    send_word(0, 1, 1, 1);
    send_word(0, ID_W'(MAX_NODES), ID_W'(MAX_NODES), 4);
    send_word(0, 0, ID_W'(MAX_NODES + 1), ID_W'(MAX_ID));
    send_word(1, 1, 2, 3);
    send_word(7, 5, 5, 6);
    send_word(2, ID_W'(MAX_NODES), 1, ID_W'(MAX_NODES));
    send_word(3, 15'h5555, 15'h2aaa, 15'h5555);
    send_word(4, 0, 0, 1);
    send_word(5, ID_W'(MAX_ID), 1, ID_W'(MAX_ID));
    send_word(6, 9, 10, 9);
    send_word(7, 7, 6, 5);
    send_word(3, 15'h2aaa, 15'h5555, 0);
    send_word(1, 4, 4, 4);

    send_idle = 12;
    recv_idle = 68;
    repeat (RANDOM_WORDS / 3) send_random_word();
    send_idle = 68;
    recv_idle = 12;
    repeat (RANDOM_WORDS / 3) send_random_word();
    send_idle = 0;
    recv_idle = 0;
    repeat (RANDOM_WORDS / 3) send_random_word();
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
